### rtl/core/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and codes for the minimum-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

  // Operation codes carried by an input transaction
  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // Status codes returned with each result
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // Fixed field widths of the channels
  localparam int unsigned FIELD_W = 32;
  localparam int unsigned COUNT_W = 7;

  // Shift command broadcast along the cell row
  typedef struct packed {
    logic push;
    logic pop;
  } mts_shift_t;

endpackage

### rtl/core/mts_if.sv
// ----------------------------------------------------------------------------
// mts_if
// Valid/ready channels for stack operations and stack results.
// ----------------------------------------------------------------------------
interface mts_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface mts_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic signed [31:0] min_value;
  logic [6:0]         count;
  logic               is_empty;
  logic [1:0]         status;

  modport source (output valid, output top_value, output min_value, output count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input top_value, input min_value, input count,
                  input is_empty, input status, output ready);
endinterface

### rtl/core/mts_cell.sv
// ----------------------------------------------------------------------------
// mts_cell
// One stack slot: a value and the running minimum of it and the entries below it.
// On a push it takes its upper neighbour's pair, on a pop its lower neighbour's pair.
// ----------------------------------------------------------------------------
module mts_cell #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  mts_pkg::mts_shift_t           shift,
  input  logic signed [VALUE_WIDTH-1:0] up_val,
  input  logic signed [VALUE_WIDTH-1:0] up_min,
  input  logic signed [VALUE_WIDTH-1:0] dn_val,
  input  logic signed [VALUE_WIDTH-1:0] dn_min,
  output logic signed [VALUE_WIDTH-1:0] val,
  output logic signed [VALUE_WIDTH-1:0] min
);

  logic signed [VALUE_WIDTH-1:0] val_r;
  logic signed [VALUE_WIDTH-1:0] min_r;

  // payload only, no reset needed
  always_ff @(posedge clk) begin
    if (shift.push) begin
      val_r <= up_val;
      min_r <= up_min;
    end else if (shift.pop) begin
      val_r <= dn_val;
      min_r <= dn_min;
    end
  end

  assign val = val_r;
  assign min = min_r;

endmodule

### rtl/core/min_tracking_stack_top.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// LIFO stack of signed values reporting top, minimum, count and status.
// ----------------------------------------------------------------------------
// The stack is a row of STACK_DEPTH cells with the top entry always in cell
// 0; a push shifts every cell down by one, a pop shifts every cell up by one,
// so each cell only ever talks to its neighbours. One transaction is taken
// per clock cycle and its result appears in the output register on the next
// cycle; a push needs a single signed compare of the new value against cell
// 0's running minimum. The input is held off only while an earlier result
// waits in the output register. A push onto a full stack is dropped with an
// overflow status, a pop of an empty stack is ignored with an underflow
// status, and top and minimum read 0 while the stack is empty.
// ----------------------------------------------------------------------------
module min_tracking_stack_top #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  mts_in_if.sink   in_ch,
  mts_out_if.source out_ch
);

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  logic                            out_valid_r;
  logic signed [mts_pkg::FIELD_W-1:0] out_top_r;
  logic signed [mts_pkg::FIELD_W-1:0] out_min_r;
  logic [mts_pkg::COUNT_W-1:0]     out_count_r;
  logic                            out_empty_r;
  logic [1:0]                      out_status_r;

  logic signed [VALUE_WIDTH-1:0] cell_val [STACK_DEPTH];
  logic signed [VALUE_WIDTH-1:0] cell_min [STACK_DEPTH];

  logic                          in_fire;
  logic                          is_full;
  logic                          push_ok;
  logic                          pop_ok;
  logic signed [VALUE_WIDTH-1:0] push_v;
  logic signed [VALUE_WIDTH-1:0] push_min;
  logic signed [VALUE_WIDTH-1:0] res_top;
  logic signed [VALUE_WIDTH-1:0] res_min;
  logic [1:0]                    res_status;
  mts_pkg::mts_shift_t           shift;

  // handshake: output register frees up as its result is taken
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // decode the operation
  assign is_full = (cnt_r == CNT_W'(STACK_DEPTH));
  assign push_ok = in_fire && (in_ch.op == mts_pkg::OP_PUSH) && !is_full;
  assign pop_ok  = in_fire && (in_ch.op == mts_pkg::OP_POP) && (cnt_r != '0);
  assign shift.push = push_ok;
  assign shift.pop  = pop_ok;

  // new entry and its running minimum
  assign push_v   = VALUE_WIDTH'(in_ch.push_value);
  assign push_min = ((cnt_r == '0) || (push_v < cell_min[0])) ? push_v : cell_min[0];

  always_comb begin
    res_status = mts_pkg::ST_OK;
    if (in_ch.op == mts_pkg::OP_PUSH && is_full) begin
      res_status = mts_pkg::ST_OVERFLOW;
    end else if (in_ch.op == mts_pkg::OP_POP && cnt_r == '0) begin
      res_status = mts_pkg::ST_UNDERFLOW;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // top and minimum as they will stand after this transaction
  always_comb begin
    if (push_ok) begin
      res_top = push_v;
      res_min = push_min;
    end else if (pop_ok) begin
      res_top = cell_val[1];
      res_min = cell_min[1];
    end else begin
      res_top = cell_val[0];
      res_min = cell_min[0];
    end
  end

  // row of cells, cell 0 holds the top entry
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] up_val;
    logic signed [VALUE_WIDTH-1:0] up_min;
    logic signed [VALUE_WIDTH-1:0] dn_val;
    logic signed [VALUE_WIDTH-1:0] dn_min;

    if (i == 0) begin : g_head
      assign up_val = push_v;
      assign up_min = push_min;
    end else begin : g_body
      assign up_val = cell_val[i-1];
      assign up_min = cell_min[i-1];
    end

    // bottom cell refills with itself; that slot is then beyond the count
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign dn_val = cell_val[i];
      assign dn_min = cell_min[i];
    end else begin : g_link
      assign dn_val = cell_val[i+1];
      assign dn_min = cell_min[i+1];
    end

    mts_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk    (clk),
      .shift  (shift),
      .up_val (up_val),
      .up_min (up_min),
      .dn_val (dn_val),
      .dn_min (dn_min),
      .val    (cell_val[i]),
      .min    (cell_min[i])
    );
  end

  // entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_top_r    <= (cnt_nxt == '0) ? '0 : mts_pkg::FIELD_W'(res_top);
      out_min_r    <= (cnt_nxt == '0) ? '0 : mts_pkg::FIELD_W'(res_min);
      out_count_r  <= mts_pkg::COUNT_W'(cnt_nxt);
      out_empty_r  <= (cnt_nxt == '0);
      out_status_r <= res_status;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.top_value = out_top_r;
  assign out_ch.min_value = out_min_r;
  assign out_ch.count     = out_count_r;
  assign out_ch.is_empty  = out_empty_r;
  assign out_ch.status    = out_status_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("entry count beyond stack depth");

  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    push_ok |=> cnt_r == $past(cnt_r) + 1'b1)
    else $error("push did not raise the count");

  // slot below a single entry may never have been written
  a_pop_shift: assert property (@(posedge clk) disable iff (!rst_n)
    pop_ok |=> (cell_val[0] === $past(cell_val[1])) && (cell_min[0] === $past(cell_min[1])))
    else $error("pop did not bring the next entry to the top");

  a_min_le_top: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0) |-> (cell_min[0] <= cell_val[0]))
    else $error("running minimum above top value");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.op == mts_pkg::OP_POP && cnt_r == '0) |=>
      out_empty_r && (out_status_r == mts_pkg::ST_UNDERFLOW))
    else $error("underflow not reported on empty stack");

endmodule
